[hdl/cplc_pkg.sv]
// ----------------------------------------------------------------------------
// cplc_pkg
// Shared types and constants of the closest-pair linkage clustering block.
// ----------------------------------------------------------------------------
package cplc_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 20;

	localparam int FIELD_COORD_W = 20;
	localparam int CFG_W         = 19;
	localparam int PROD_W        = 26;
	localparam int XPROD_W       = 40;
	localparam int APB_DATA_W    = 32;
	localparam int APB_ADDR_W    = 3;

	localparam logic [CFG_W-1:0]      PAIRS_RESET      = CFG_W'(1000);
	localparam logic [APB_ADDR_W-1:0] ADDR_PAIRS_TO_CONNECT = '0;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_CHECK,
		S_MEAS,
		S_MUL1,
		S_MUL2,
		S_SCAN,
		S_JOIN_RD,
		S_JOIN_UPD,
		S_RELAB,
		S_SIZE_RD,
		S_SIZE_UPD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic init_run;
		logic meas_clr;
		logic meas_run;
		logic mul1;
		logic mul2;
		logic scan_clr;
		logic scan_run;
		logic set_exh;
		logic join_rd;
		logic join_upd;
		logic relab_run;
		logic size_rd;
		logic size_upd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic k_done;
		logic k_busy;
		logic scan_done;
		logic have_best;
		logic lab_eq;
		logic measured;
		logic closed;
		logic exhausted;
		logic pj_reached;
	} sts_t;

endpackage

[hdl/cplc_ctrl.sv]
// ----------------------------------------------------------------------------
// cplc_ctrl
// Sequencer of the clustering block: loading, pair scans, joins, measuring.
// ----------------------------------------------------------------------------
module cplc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          last_point,
	input  cplc_pkg::sts_t sts,
	output cplc_pkg::cmd_t cmd,
	output logic          busy
);
	import cplc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && last_point) state_d = S_INIT;
			end
			S_INIT: begin
				if (sts.k_done) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!sts.measured && (sts.pj_reached || sts.closed || sts.exhausted))
					state_d = S_MEAS;
				else if ((sts.measured && sts.closed) || sts.exhausted)
					state_d = S_OUT;
				else
					state_d = S_SCAN;
			end
			S_MEAS: begin
				if (sts.k_done && !sts.k_busy) state_d = S_MUL1;
			end
			S_MUL1:     state_d = S_MUL2;
			S_MUL2:     state_d = S_CHECK;
			S_SCAN: begin
				if (sts.scan_done) state_d = sts.have_best ? S_JOIN_RD : S_CHECK;
			end
			S_JOIN_RD:  state_d = S_JOIN_UPD;
			S_JOIN_UPD: state_d = sts.lab_eq ? S_CHECK : S_RELAB;
			S_RELAB: begin
				if (sts.k_done && !sts.k_busy) state_d = S_SIZE_RD;
			end
			S_SIZE_RD:  state_d = S_SIZE_UPD;
			S_SIZE_UPD: state_d = S_CHECK;
			S_OUT:      state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:     cmd.load = start;
			S_INIT:     cmd.init_run = 1'b1;
			S_CHECK: begin
				if (!sts.measured && (sts.pj_reached || sts.closed || sts.exhausted))
					cmd.meas_clr = 1'b1;
				else if (!((sts.measured && sts.closed) || sts.exhausted))
					cmd.scan_clr = 1'b1;
			end
			S_MEAS:     cmd.meas_run = 1'b1;
			S_MUL1:     cmd.mul1 = 1'b1;
			S_MUL2:     cmd.mul2 = 1'b1;
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				cmd.set_exh  = sts.scan_done && !sts.have_best;
			end
			S_JOIN_RD:  cmd.join_rd = 1'b1;
			S_JOIN_UPD: cmd.join_upd = 1'b1;
			S_RELAB:    cmd.relab_run = 1'b1;
			S_SIZE_RD:  cmd.size_rd = 1'b1;
			S_SIZE_UPD: cmd.size_upd = 1'b1;
			S_OUT:      cmd.finish = 1'b1;
			default:    cmd = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

[hdl/cplc_dpath.sv]
// ----------------------------------------------------------------------------
// cplc_dpath
// Point, label and size memories, the pair distance pipeline and the
// measuring and product arithmetic of the clustering block.
// ----------------------------------------------------------------------------
module cplc_dpath #(
	parameter int MAX_POINTS = cplc_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = cplc_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cplc_pkg::cmd_t                         cmd,
	output cplc_pkg::sts_t                         sts,
	input  logic [cplc_pkg::FIELD_COORD_W-1:0]     x_coord,
	input  logic [cplc_pkg::FIELD_COORD_W-1:0]     y_coord,
	input  logic [cplc_pkg::FIELD_COORD_W-1:0]     z_coord,
	input  logic                                   last_point,
	input  logic [cplc_pkg::CFG_W-1:0]             pairs_to_connect,
	output logic [cplc_pkg::PROD_W-1:0]            three_largest_product,
	output logic                                   three_largest_valid,
	output logic [cplc_pkg::XPROD_W-1:0]           closing_pair_x_product,
	output logic                                   closing_pair_valid
);
	import cplc_pkg::*;

	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int CB  = COORD_BITS;
	localparam int SQW = 2 * CB;
	localparam int DW  = 2 * CB + 2;
	localparam int PJW = 20;
	localparam int FW  = (3 * CW > PROD_W) ? 3 * CW : PROD_W;
	localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

	// Memories
	logic [CB-1:0] x_mem [MAX_POINTS];
	logic [CB-1:0] y_mem [MAX_POINTS];
	logic [CB-1:0] z_mem [MAX_POINTS];
	logic [AW-1:0] lab_mem [MAX_POINTS];
	logic [CW-1:0] size_mem [MAX_POINTS];

	logic [CW-1:0] cnt_q, k_q, cc_q;
	logic [AW-1:0] k_s1;
	logic          kv_s1;
	logic [PJW-1:0] pj_q;
	logic          measured_q, closed_q, exh_q;

	logic [CW-1:0] i_q, j_q;
	logic          issuing_q;
	logic          v_s1, v_s2, v_s3, v_s4;
	logic [AW-1:0] i_s1, j_s1, i_s2, j_s2, i_s3, j_s3, i_s4, j_s4;
	logic [CB-1:0] xa_q, xb_q, ya_q, yb_q, za_q, zb_q;
	logic signed [CB:0] dx_s2, dy_s2, dz_s2;
	logic [SQW-1:0] sqx_s3, sqy_s3, sqz_s3;
	logic [DW-1:0]  d_s4;
	logic signed [2*CB+1:0] px, py, pz;

	logic [DW-1:0] best_d_q, prev_d_q;
	logic [AW-1:0] best_i_q, best_j_q, prev_i_q, prev_j_q;
	logic          have_best_q;

	logic [AW-1:0] laba_q, labb_q, la_q, lb_q;
	logic [CW-1:0] sza_q, szb_q;
	logic [CB-1:0] jxa_q, jxb_q;

	logic [CW-1:0] t1_q, t2_q, t3_q;
	logic [2*CW-1:0] p1_q;
	logic [2*CW-1:0] p1;
	logic [FW-1:0]   pfull;
	logic [PROD_W-1:0] prod_q;
	logic            pvalid_q;
	logic signed [XPROD_W-1:0] xp;
	logic [XPROD_W-1:0] xprod_q;

	logic [AW-1:0] rda, rdb, lra, sra;
	logic          gt_prev, take;
	logic          issue_k;

	assign issue_k = (cmd.meas_run || cmd.relab_run) && (k_q < cnt_q);

	// Point memories: written while loading, read at two addresses.
	assign rda = cmd.join_rd ? best_i_q : i_q[AW-1:0];
	assign rdb = cmd.join_rd ? best_j_q : j_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load && (cnt_q < MAXC)) begin
			x_mem[cnt_q[AW-1:0]] <= x_coord[CB-1:0];
			y_mem[cnt_q[AW-1:0]] <= y_coord[CB-1:0];
			z_mem[cnt_q[AW-1:0]] <= z_coord[CB-1:0];
		end
		xa_q <= x_mem[rda];
		xb_q <= x_mem[rdb];
		ya_q <= y_mem[rda];
		yb_q <= y_mem[rdb];
		za_q <= z_mem[rda];
		zb_q <= z_mem[rdb];
	end

	// Label and size memories.
	assign lra = cmd.join_rd ? best_i_q : k_q[AW-1:0];
	assign sra = cmd.size_rd ? la_q : k_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.init_run && (k_q < cnt_q))
			lab_mem[k_q[AW-1:0]] <= k_q[AW-1:0];
		else if (cmd.relab_run && kv_s1 && (laba_q == lb_q))
			lab_mem[k_s1] <= la_q;
		laba_q <= lab_mem[lra];
		labb_q <= lab_mem[best_j_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.init_run && (k_q < cnt_q))
			size_mem[k_q[AW-1:0]] <= CW'(1);
		else if (cmd.size_upd)
			size_mem[la_q] <= sza_q + szb_q;
		sza_q <= size_mem[sra];
		szb_q <= size_mem[lb_q];
	end

	// Control state of the evaluation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			k_q         <= '0;
			kv_s1       <= 1'b0;
			cc_q        <= '0;
			pj_q        <= '0;
			measured_q  <= 1'b0;
			closed_q    <= 1'b0;
			exh_q       <= 1'b0;
			issuing_q   <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			have_best_q <= 1'b0;
			prev_d_q    <= '0;
			prev_i_q    <= '0;
			prev_j_q    <= '0;
			pvalid_q    <= 1'b0;
		end else begin
			kv_s1 <= issue_k;
			if (cmd.load) begin
				if (cnt_q < MAXC) cnt_q <= cnt_q + CW'(1);
				if (last_point) begin
					cc_q       <= (cnt_q < MAXC) ? cnt_q + CW'(1) : cnt_q;
					k_q        <= '0;
					pj_q       <= '0;
					measured_q <= 1'b0;
					closed_q   <= 1'b0;
					exh_q      <= 1'b0;
					prev_d_q   <= '0;
					prev_i_q   <= '0;
					prev_j_q   <= '0;
					pvalid_q   <= 1'b0;
				end
			end
			if (cmd.init_run && (k_q < cnt_q)) k_q <= k_q + CW'(1);
			if (issue_k) k_q <= k_q + CW'(1);
			if (cmd.meas_clr || cmd.join_upd) k_q <= '0;
			if (cmd.mul2) begin
				measured_q <= 1'b1;
				pvalid_q   <= (cc_q >= CW'(3));
			end
			if (cmd.set_exh) exh_q <= 1'b1;

			// Pair scan over first < second.
			if (cmd.scan_clr) begin
				issuing_q   <= (cnt_q >= CW'(2));
				have_best_q <= 1'b0;
			end else if (cmd.scan_run && issuing_q) begin
				if (j_q == cnt_q - CW'(1)) begin
					if (i_q + CW'(2) > cnt_q - CW'(1)) issuing_q <= 1'b0;
				end
			end
			v_s1 <= cmd.scan_run && issuing_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4 && take) have_best_q <= 1'b1;

			if (cmd.join_upd) begin
				pj_q     <= pj_q + PJW'(1);
				prev_d_q <= best_d_q;
				prev_i_q <= best_i_q;
				prev_j_q <= best_j_q;
			end
			if (cmd.size_upd) begin
				cc_q <= cc_q - CW'(1);
				if ((cc_q == CW'(2)) && !closed_q) closed_q <= 1'b1;
			end
			if (cmd.finish) cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_clr) begin
			i_q <= '0;
			j_q <= CW'(1);
		end else if (cmd.scan_run && issuing_q) begin
			if (j_q == cnt_q - CW'(1)) begin
				i_q <= i_q + CW'(1);
				j_q <= i_q + CW'(2);
			end else begin
				j_q <= j_q + CW'(1);
			end
		end
		k_s1 <= k_q[AW-1:0];
		i_s1 <= i_q[AW-1:0];
		j_s1 <= j_q[AW-1:0];
		i_s2 <= i_s1;
		j_s2 <= j_s1;
		i_s3 <= i_s2;
		j_s3 <= j_s2;
		i_s4 <= i_s3;
		j_s4 <= j_s3;
		dx_s2 <= $signed({xa_q[CB-1], xa_q}) - $signed({xb_q[CB-1], xb_q});
		dy_s2 <= $signed({ya_q[CB-1], ya_q}) - $signed({yb_q[CB-1], yb_q});
		dz_s2 <= $signed({za_q[CB-1], za_q}) - $signed({zb_q[CB-1], zb_q});
		sqx_s3 <= px[SQW-1:0];
		sqy_s3 <= py[SQW-1:0];
		sqz_s3 <= pz[SQW-1:0];
		d_s4 <= DW'(sqx_s3) + DW'(sqy_s3) + DW'(sqz_s3);
		if (v_s4 && take) begin
			best_d_q <= d_s4;
			best_i_q <= i_s4;
			best_j_q <= j_s4;
		end
	end

	assign px = dx_s2 * dx_s2;
	assign py = dy_s2 * dy_s2;
	assign pz = dz_s2 * dz_s2;

	// The next pair lies strictly after the last one joined; equal distances
	// meet in scan order, so the first one seen wins.
	assign gt_prev = (d_s4 > prev_d_q) ||
		((d_s4 == prev_d_q) && ({i_s4, j_s4} > {prev_i_q, prev_j_q}));
	assign take = (d_s4 != '0) && gt_prev && (!have_best_q || (d_s4 < best_d_q));

	// Join and component arithmetic.
	assign xp = $signed(jxa_q) * $signed(jxb_q);

	always_ff @(posedge clk) begin
		if (cmd.join_upd) begin
			la_q  <= laba_q;
			lb_q  <= labb_q;
			jxa_q <= xa_q;
			jxb_q <= xb_q;
		end
		if (cmd.load && last_point) xprod_q <= '0;
		else if (cmd.size_upd && (cc_q == CW'(2)) && !closed_q) xprod_q <= xp;
		if (cmd.meas_clr) begin
			t1_q <= '0;
			t2_q <= '0;
			t3_q <= '0;
		end else if (cmd.meas_run && kv_s1 && (laba_q == k_s1)) begin
			if (sza_q > t1_q) begin
				t3_q <= t2_q;
				t2_q <= t1_q;
				t1_q <= sza_q;
			end else if (sza_q > t2_q) begin
				t3_q <= t2_q;
				t2_q <= sza_q;
			end else if (sza_q > t3_q) begin
				t3_q <= sza_q;
			end
		end
		if (cmd.mul1) p1_q <= p1;
		if (cmd.mul2) prod_q <= (cc_q >= CW'(3)) ? pfull[PROD_W-1:0] : '0;
	end

	assign p1    = t1_q * t2_q;
	assign pfull = FW'(p1_q) * FW'(t3_q);

	assign sts.k_done     = (k_q >= cnt_q);
	assign sts.k_busy     = kv_s1;
	assign sts.scan_done  = !issuing_q && !v_s1 && !v_s2 && !v_s3 && !v_s4;
	assign sts.have_best  = have_best_q;
	assign sts.lab_eq     = (laba_q == labb_q);
	assign sts.measured   = measured_q;
	assign sts.closed     = closed_q;
	assign sts.exhausted  = exh_q;
	assign sts.pj_reached = (pj_q >= PJW'(pairs_to_connect));

	assign three_largest_product  = prod_q;
	assign three_largest_valid    = pvalid_q;
	assign closing_pair_x_product = xprod_q;
	assign closing_pair_valid     = closed_q;

endmodule

[hdl/closest_pair_linkage_clustering.sv]
// ----------------------------------------------------------------------------
// closest_pair_linkage_clustering
// Single-linkage clustering of 3D integer points, joined closest pair first.
// ----------------------------------------------------------------------------
// Points are loaded one transaction per cycle while busy is low; a point
// beyond the store depth is dropped. The point marked last starts the
// evaluation, during which busy stays high and start is ignored. The
// evaluation first sets up the components, then for every pair joined runs
// one full scan of all n(n-1)/2 pairs through the distance pipeline, fed by
// the single pair per cycle read of the point memories, plus a pass to
// relabel a merged component and the one pass that measures component sizes.
// The result is shown for exactly one cycle with done high and cannot be held
// off by the receiver; afterwards a new point set begins.
module closest_pair_linkage_clustering #(
	parameter int MAX_POINTS = cplc_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = cplc_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [cplc_pkg::FIELD_COORD_W-1:0] x_coord,
	input  logic [cplc_pkg::FIELD_COORD_W-1:0] y_coord,
	input  logic [cplc_pkg::FIELD_COORD_W-1:0] z_coord,
	input  logic                               last_point,
	output logic                               done,
	output logic [cplc_pkg::PROD_W-1:0]        three_largest_product,
	output logic                               three_largest_valid,
	output logic [cplc_pkg::XPROD_W-1:0]       closing_pair_x_product,
	output logic                               closing_pair_valid,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cplc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [cplc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [cplc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);
	import cplc_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [CFG_W-1:0] pairs_q;
	logic             cfg_wr;

	// The register is written in the access phase of an APB write transaction;
	// addresses other than the one register are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q <= PAIRS_RESET;
		end else if (cfg_wr && (paddr == ADDR_PAIRS_TO_CONNECT)) begin
			pairs_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr == ADDR_PAIRS_TO_CONNECT) ? APB_DATA_W'(pairs_q) : '0;

	cplc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start && !busy),
		.last_point (last_point),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy)
	);

	cplc_dpath #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_dpath (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.sts                    (sts),
		.x_coord                (x_coord),
		.y_coord                (y_coord),
		.z_coord                (z_coord),
		.last_point             (last_point),
		.pairs_to_connect       (pairs_q),
		.three_largest_product  (three_largest_product),
		.three_largest_valid    (three_largest_valid),
		.closing_pair_x_product (closing_pair_x_product),
		.closing_pair_valid     (closing_pair_valid)
	);

	// The result strobe comes from the final state of an evaluation.
	assign done = cmd.finish;

`ifndef SYNTHESIS
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block still busy after a result");
	a_done_was_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without an evaluation");
	a_point_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_point) |=> !busy)
		else $error("a plain point started an evaluation");
	a_prod_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !three_largest_valid) |-> (three_largest_product == '0))
		else $error("invalid size product is not zero");
`endif

endmodule

[test/cplc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplc_checker
// Watches the point, result and register channels and checks every result.
// ----------------------------------------------------------------------------
module cplc_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [cplc_pkg::FIELD_COORD_W-1:0] x_coord,
	input  logic [cplc_pkg::FIELD_COORD_W-1:0] y_coord,
	input  logic [cplc_pkg::FIELD_COORD_W-1:0] z_coord,
	input  logic                               last_point,
	input  logic                               done,
	input  logic [cplc_pkg::PROD_W-1:0]        three_largest_product,
	input  logic                               three_largest_valid,
	input  logic [cplc_pkg::XPROD_W-1:0]       closing_pair_x_product,
	input  logic                               closing_pair_valid,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cplc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [cplc_pkg::APB_DATA_W-1:0]    pwdata,
	input  logic                               pready,
	output int                                 expected_left,
	output int                                 fail_count
);
	import cplc_pkg::*;

	localparam int DEPTH = MAX_POINTS_DEF;

	typedef struct packed {
		logic [PROD_W-1:0]  prod;
		logic               prod_ok;
		logic [XPROD_W-1:0] xprod;
		logic               xprod_ok;
	} cluster_result_t;

	logic signed [FIELD_COORD_W-1:0] px [DEPTH];
	logic signed [FIELD_COORD_W-1:0] py [DEPTH];
	logic signed [FIELD_COORD_W-1:0] pz [DEPTH];
	int                              n_points;
	logic [CFG_W-1:0]                pairs_cfg;
	int                              label [DEPTH];
	int                              csize [DEPTH];
	cluster_result_t                 pending_results [$];

	assign expected_left = pending_results.size();

	// Product of the three largest component sizes, masked to the field.
	function automatic logic [PROD_W-1:0] top_three_product(int n);
		longint unsigned a, b, c, s;
		a = 0;
		b = 0;
		c = 0;
		for (int k = 0; k < n; k++) begin
			if (label[k] != k)
				continue;
			s = csize[k];
			if (s > a) begin
				c = b; b = a; a = s;
			end else if (s > b) begin
				c = b; b = s;
			end else if (s > c) begin
				c = s;
			end
		end
		return PROD_W'(a * b * c);
	endfunction

	// Ranks all distinct pairs and joins them closest first.
	function automatic cluster_result_t cluster_points();
		longint unsigned dist_q [$];
		int              code_q [$];
		longint unsigned d, dx2, dy2, dz2;
		longint          dx, dy, dz, xp;
		int              n, pos, idx, joined, comps, a, b, la, lb;
		bit              measured, closed;
		cluster_result_t r;
		r = '0;
		n = n_points;
		for (int i = 0; i < n; i++) begin
			for (int j = i + 1; j < n; j++) begin
				dx = longint'(px[i]) - longint'(px[j]);
				dy = longint'(py[i]) - longint'(py[j]);
				dz = longint'(pz[i]) - longint'(pz[j]);
				dx2 = dx * dx;
				dy2 = dy * dy;
				dz2 = dz * dz;
				d = dx2 + dy2 + dz2;
				if (d == 0)
					continue;
				// Stable insertion keeps pairs of equal distance in index order.
				pos = dist_q.size();
				while (pos > 0 && dist_q[pos-1] > d)
					pos--;
				dist_q.insert(pos, d);
				code_q.insert(pos, i * DEPTH + j);
			end
		end
		for (int i = 0; i < n; i++) begin
			label[i] = i;
			csize[i] = 1;
		end
		comps = n;
		idx = 0;
		joined = 0;
		measured = 0;
		closed = 0;
		while (1) begin
			if (!measured && (joined >= int'(pairs_cfg) || closed)) begin
				r.prod = (comps >= 3) ? top_three_product(n) : '0;
				r.prod_ok = (comps >= 3);
				measured = 1;
			end
			if ((measured && closed) || idx == dist_q.size())
				break;
			a = code_q[idx] / DEPTH;
			b = code_q[idx] % DEPTH;
			idx++;
			joined++;
			la = label[a];
			lb = label[b];
			if (la != lb) begin
				for (int m = 0; m < n; m++)
					if (label[m] == lb)
						label[m] = la;
				csize[la] += csize[lb];
				comps--;
				if (comps == 1 && !closed) begin
					xp = longint'(px[a]) * longint'(px[b]);
					r.xprod = xp[XPROD_W-1:0];
					r.xprod_ok = 1'b1;
					closed = 1;
				end
			end
		end
		if (!measured) begin
			r.prod = (comps >= 3) ? top_three_product(n) : '0;
			r.prod_ok = (comps >= 3);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cluster_result_t exp_r, got_r;
		if (!arst_n) begin
			n_points = 0;
			pairs_cfg = PAIRS_RESET;
			fail_count <= 0;
			pending_results.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_PAIRS_TO_CONNECT)
				pairs_cfg = pwdata[CFG_W-1:0];
			if (start && !busy) begin
				if (n_points < DEPTH) begin
					px[n_points] = x_coord;
					py[n_points] = y_coord;
					pz[n_points] = z_coord;
					n_points = n_points + 1;
				end
				if (last_point) begin
					pending_results.insert(pending_results.size(), cluster_points());
					n_points = 0;
				end
			end
			if (done) begin
				got_r = '{three_largest_product, three_largest_valid,
					closing_pair_x_product, closing_pair_valid};
				if (pending_results.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result with none expected: %p", $realtime, got_r);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = pending_results.pop_front();
					if (got_r !== exp_r) begin
						if (fail_count < 10)
							$display("%0t: mismatch, expected %p, got %p",
								$realtime, exp_r, got_r);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the clustering testbench: point stimulus, register writes, verdict.
// ----------------------------------------------------------------------------
// Point sets are kept small, because the block rescans every pair for each
// pair that it joins, so its run time grows with the fourth power of the set
// size. A directed part covers the single point, identical points, extreme
// coordinates, ties and the register extremes; then random sets follow in
// phases with different amounts of sender idling. The checker beside the
// block predicts and compares each result transaction; this module only
// drives and gives the verdict.
module tb;
	import cplc_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [FIELD_COORD_W-1:0] x_coord, y_coord, z_coord;
	logic                     last_point;
	logic                     done;
	logic [PROD_W-1:0]        three_largest_product;
	logic                     three_largest_valid;
	logic [XPROD_W-1:0]       closing_pair_x_product;
	logic                     closing_pair_valid;
	logic                     psel, penable, pwrite;
	logic [APB_ADDR_W-1:0]    paddr;
	logic [APB_DATA_W-1:0]    pwdata;
	logic [APB_DATA_W-1:0]    prdata;
	logic                     pready;
	int                       expected_left;
	int                       fail_count;
	int                       cycle_count = 0;
	int                       idle_pct;
	int                       points_sent;

	closest_pair_linkage_clustering i_dut (.*);

	cplc_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung block must not stall the run for ever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// One register write: the setup phase, then the access phase until pready.
	task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Holds the sender back until every result has come and the block is idle.
	task automatic wait_idle();
		start <= 1'b0;
		while (expected_left != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Offers one point and returns once the block has taken it. Start is left
	// high so that back-to-back transactions follow without a gap.
	task automatic send_point(logic [FIELD_COORD_W-1:0] x, logic [FIELD_COORD_W-1:0] y,
			logic [FIELD_COORD_W-1:0] z, logic last);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		x_coord <= x;
		y_coord <= y;
		z_coord <= z;
		last_point <= last;
		do @(posedge clk); while (busy);
		points_sent++;
	endtask

	// Coordinates: a tiny range gives ties and identical points, the extremes
	// and full-range values exercise every bit and the widest distances.
	function automatic logic [FIELD_COORD_W-1:0] pick_coord(int style);
		case (style)
			0: return FIELD_COORD_W'($urandom_range(0, 6) - 3);
			1: begin
				case ($urandom_range(3))
					0: return {1'b1, {(FIELD_COORD_W-1){1'b0}}};
					1: return {1'b0, {(FIELD_COORD_W-1){1'b1}}};
					2: return '0;
					default: return '1;
				endcase
			end
			default: return FIELD_COORD_W'($urandom);
		endcase
	endfunction

	task automatic send_random_set();
		int n, style;
		n = ($urandom_range(19) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
		style = $urandom_range(2);
		for (int k = 0; k < n; k++)
			send_point(pick_coord(style), pick_coord(style), pick_coord(style), k == n - 1);
	endtask

	initial begin
		logic [FIELD_COORD_W-1:0] lo, hi;
		arst_n = 1'b0;
		start = 1'b0;
		x_coord = '0;
		y_coord = '0;
		z_coord = '0;
		last_point = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_pct = 0;
		points_sent = 0;
		lo = {1'b1, {(FIELD_COORD_W-1){1'b0}}};
		hi = {1'b0, {(FIELD_COORD_W-1){1'b1}}};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first with the register at its reset value.
		// A lone point: no pair exists at all.
		send_point(lo, lo, lo, 1'b1);
		// Two identical points are never joined.
		send_point(hi, 20'h00005, lo, 1'b0);
		send_point(hi, 20'h00005, lo, 1'b1);
		// Opposite corners of the coordinate cube: the widest distance.
		send_point(lo, lo, lo, 1'b0);
		send_point(hi, hi, hi, 1'b1);
		wait_idle();
		// Register at zero: sizes are measured before any join.
		write_reg(ADDR_PAIRS_TO_CONNECT, 32'd0);
		send_point(20'd0, 20'd0, 20'd0, 1'b0);
		send_point(20'd5, 20'd0, 20'd0, 1'b0);
		send_point(20'd100, 20'd0, 20'd0, 1'b1);
		wait_idle();
		// One pair, then a square whose edges all tie.
		write_reg(ADDR_PAIRS_TO_CONNECT, 32'd1);
		send_point(20'd0, 20'd0, 20'd0, 1'b0);
		send_point(20'd1, 20'd0, 20'd0, 1'b0);
		send_point(20'd0, 20'd1, 20'd0, 1'b0);
		send_point(20'd1, 20'd1, 20'd0, 1'b1);
		wait_idle();
		// Largest register value with upper bits set, and a write to an
		// unused address: pairs run out before one component forms.
		write_reg(ADDR_PAIRS_TO_CONNECT, 32'hFFFF_FFFF);
		write_reg(APB_ADDR_W'(4), 32'd2);
		send_point(20'd3, 20'd3, 20'd3, 1'b0);
		send_point(20'd3, 20'd3, 20'd3, 1'b0);
		send_point(lo, 20'd7, hi, 1'b0);
		send_point(20'hFFFFF, 20'd0, 20'd9, 1'b0);
		send_point(20'd2, hi, lo, 1'b1);

		// Random phases: no idling, heavy sender idling, none again, light.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 87 : (ph == 3) ? 31 : 0;
			while (points_sent < 22 + (ph + 1) * 195) begin
				// Now and then the sender pauses for every result and the
				// register is moved, mostly to small values.
				if ($urandom_range(3) == 0) begin
					wait_idle();
					case ($urandom_range(5))
						0: write_reg(ADDR_PAIRS_TO_CONNECT, 32'd0);
						1: write_reg(ADDR_PAIRS_TO_CONNECT, 32'd523776);
						2: write_reg(ADDR_PAIRS_TO_CONNECT, $urandom);
						default: write_reg(ADDR_PAIRS_TO_CONNECT, $urandom_range(1, 30));
					endcase
				end
				send_random_set();
			end
		end

		// The last evaluation may still be running; wait for its result.
		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_left == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
hdl/cplc_pkg.sv
hdl/cplc_ctrl.sv
hdl/cplc_dpath.sv
hdl/closest_pair_linkage_clustering.sv
test/cplc_checker.sv
test/tb.sv
